[rtl/mts_pkg.sv]
// ----------------------------------------------------------------------------
// mts_pkg
// Shared types and constants for the mention token scanner.
// ----------------------------------------------------------------------------
package mts_pkg;

    localparam int unsigned CHAR_W = 8;
    localparam int unsigned KIND_W = 2;
    localparam int unsigned OPOS_W = 16;
    localparam int unsigned ID_W   = 31;
    localparam int unsigned CNT_W  = 8;

    typedef logic [CHAR_W-1:0] t_char;
    typedef logic [KIND_W-1:0] t_kind;
    typedef logic [OPOS_W-1:0] t_opos;
    typedef logic [ID_W-1:0]   t_id;
    typedef logic [CNT_W-1:0]  t_cnt;

    // Mention kinds as carried on the result channel.
    localparam t_kind KIND_USER = 2'd0;
    localparam t_kind KIND_ROLE = 2'd1;
    localparam t_kind KIND_ALL  = 2'd2;

    // Characters the scanner looks for.
    localparam t_char CH_AT    = 8'h40;  // '@'
    localparam t_char CH_USER  = 8'h75;  // 'u'
    localparam t_char CH_ROLE  = 8'h72;  // 'r'
    localparam t_char CH_ALL   = 8'h65;  // 'e'
    localparam t_char CH_ZERO  = 8'h30;  // '0'
    localparam t_char CH_NINE  = 8'h39;  // '9'

    localparam t_id  ID_MAX        = 31'h7FFF_FFFF;
    localparam t_cnt CNT_MAX       = 8'hFF;
    localparam t_cnt MAX_FOUND_RST = 8'd16;

endpackage

[rtl/mts_text_if.sv]
// ----------------------------------------------------------------------------
// mts_text_if
// Request channel carrying one text character and its end-of-text flag.
// ----------------------------------------------------------------------------
interface mts_text_if;
    import mts_pkg::*;

    logic  valid;
    logic  ready;
    t_char text_char;
    logic  text_last;

    modport source (output valid, output text_char, output text_last, input ready);
    modport sink   (input valid, input text_char, input text_last, output ready);

endinterface

[rtl/mts_mention_if.sv]
// ----------------------------------------------------------------------------
// mts_mention_if
// Request channel carrying one recognized mention.
// ----------------------------------------------------------------------------
interface mts_mention_if;
    import mts_pkg::*;

    logic  valid;
    logic  ready;
    t_kind mention_kind;
    t_opos begin_pos;
    t_opos end_pos;
    t_id   mention_id;

    modport source (
        output valid, output mention_kind, output begin_pos, output end_pos,
        output mention_id, input ready
    );
    modport sink (
        input valid, input mention_kind, input begin_pos, input end_pos,
        input mention_id, output ready
    );

endinterface

[rtl/mention_token_scanner_core.sv]
// ----------------------------------------------------------------------------
// mention_token_scanner_core
// Streams text one character per request and reports '@e', '@u<id>' and
// '@r<id>' mentions with their kind, position span and decimal id.
// ----------------------------------------------------------------------------
//
//  channel     dir  handshake          payload
//  i_text      in   valid / ready      text_char[7:0], text_last
//  o_mention   out  valid / ready      mention_kind[1:0], begin_pos[15:0],
//                                      end_pos[15:0], mention_id[30:0]
//  i_cfg_*     in   write enable only  max_found[7:0]
//
//  One character per cycle sustained while the result channel is not stalled.
//  A request is taken into the input register and, when the scan stage
//  advances, scanned into the result register, which offers the mention
//  on o_mention until it is taken.
//  The scan state, the accumulate (x10 as shift-and-add) and the limit
//  compare all settle in that single stage. Synchronous active-low reset
//  clears the scan state and sets max_found to 16. A stalled result
//  holds the scan stage; an empty input register still takes one request.
// ----------------------------------------------------------------------------
module mention_token_scanner_core #(
    parameter int unsigned POS_BITS = 16
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    mts_text_if.sink             i_text,
    mts_mention_if.source        o_mention,
    input  logic                 i_cfg_wr_en,
    input  mts_pkg::t_cnt        i_cfg_wr_data
);
    import mts_pkg::*;

    typedef logic [POS_BITS-1:0] t_pos;

    // Scan phase, one-hot.
    typedef enum logic [3:0] {
        PH_SEEK  = 4'b0001,  // looking for '@'
        PH_TYPE  = 4'b0010,  // '@' seen, judge type character
        PH_AWAIT = 4'b0100,  // 'u' or 'r' seen, want first digit
        PH_ID    = 4'b1000   // collecting id digits
    } t_phase;

    // ------------------------------------------------------------------
    // Configuration register
    // ------------------------------------------------------------------
    t_cnt r_max_found;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_found <= MAX_FOUND_RST;
        end else if (i_cfg_wr_en) begin
            r_max_found <= i_cfg_wr_data;
        end
    end

    // ------------------------------------------------------------------
    // Input register
    // ------------------------------------------------------------------
    logic  r_in_valid;
    t_char r_in_char;
    logic  r_in_last;
    logic  w_advance;   // scan stage may move this cycle
    logic  w_in_take;

    // Scan stage may advance whenever the result register is free or drains.
    assign w_advance    = !o_mention.valid || o_mention.ready;
    assign i_text.ready = !r_in_valid || w_advance;
    assign w_in_take    = i_text.valid && i_text.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_text.ready) begin
            r_in_valid <= i_text.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_take) begin
            r_in_char <= i_text.text_char;
            r_in_last <= i_text.text_last;
        end
    end

    // ------------------------------------------------------------------
    // Scan state
    // ------------------------------------------------------------------
    t_phase r_phase,  n_phase;
    t_kind  r_kind,   n_kind;
    t_pos   r_dstart, n_dstart;
    t_id    r_acc,    n_acc;
    t_pos   r_pos,    n_pos;
    t_cnt   r_found,  n_found;

    // Result fields computed from the current character.
    logic   w_emit;
    t_kind  w_ekind;
    t_pos   w_ebegin;
    t_pos   w_eend;
    t_id    w_eid;

    logic         w_digit;
    logic [34:0]  w_acc_wide;
    t_id          w_acc_base;
    t_id          w_acc_next;
    t_cnt         w_found_inc;

    assign w_digit = (r_in_char >= CH_ZERO) && (r_in_char <= CH_NINE);

    // First digit starts from zero; later digits extend the running id.
    assign w_acc_base = (r_phase == PH_AWAIT) ? '0 : r_acc;
    assign w_acc_wide = {1'b0, w_acc_base, 3'b000} + {3'b000, w_acc_base, 1'b0}
                        + {31'd0, r_in_char[3:0]};
    assign w_acc_next = (w_acc_wide > {4'd0, ID_MAX}) ? ID_MAX : w_acc_wide[ID_W-1:0];

    // Found count after one more mention, saturating.
    assign w_found_inc = (r_found == CNT_MAX) ? r_found : r_found + 8'd1;

    always_comb begin
        n_phase  = r_phase;
        n_kind   = r_kind;
        n_dstart = r_dstart;
        n_acc    = r_acc;
        n_pos    = r_pos + t_pos'(1);
        n_found  = r_found;
        w_emit   = 1'b0;
        w_ekind  = r_kind;
        w_ebegin = r_dstart - t_pos'(2);
        w_eend   = r_pos;
        w_eid    = r_acc;

        if (r_found < r_max_found) begin
            unique case (r_phase) inside
                PH_SEEK: begin
                    if (r_in_char == CH_AT) begin
                        n_phase = PH_TYPE;
                    end
                end
                PH_TYPE, PH_AWAIT: begin
                    if (r_phase == PH_AWAIT && w_digit) begin
                        // First id digit.
                        n_dstart = r_pos;
                        n_acc    = w_acc_next;
                        n_phase  = PH_ID;
                        if (r_in_last) begin
                            w_emit   = 1'b1;
                            w_ebegin = r_pos - t_pos'(2);
                            w_eid    = w_acc_next;
                        end
                    end else if (r_in_char == CH_USER || r_in_char == CH_ROLE) begin
                        n_kind  = (r_in_char == CH_USER) ? KIND_USER : KIND_ROLE;
                        n_phase = PH_AWAIT;
                    end else begin
                        n_phase = PH_SEEK;
                        if (r_in_char == CH_ALL) begin
                            w_emit   = 1'b1;
                            w_ekind  = KIND_ALL;
                            w_ebegin = r_pos - t_pos'(1);
                            w_eid    = '0;
                        end
                    end
                end
                PH_ID: begin
                    if (w_digit) begin
                        n_acc = w_acc_next;
                        if (r_in_last) begin
                            w_emit = 1'b1;
                            w_eid  = w_acc_next;
                        end
                    end else begin
                        // Close the id at the previous digit; rescan this
                        // character for '@' unless the limit is now reached.
                        w_emit  = 1'b1;
                        w_eend  = r_pos - t_pos'(1);
                        n_phase = PH_SEEK;
                        if (w_found_inc < r_max_found && r_in_char == CH_AT) begin
                            n_phase = PH_TYPE;
                        end
                    end
                end
                default: begin
                    n_phase = PH_SEEK;
                end
            endcase
        end

        if (w_emit) begin
            n_found = w_found_inc;
        end

        // End of text: drop all scan state.
        if (r_in_last) begin
            n_phase  = PH_SEEK;
            n_kind   = KIND_USER;
            n_dstart = '0;
            n_acc    = '0;
            n_pos    = '0;
            n_found  = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase  <= PH_SEEK;
            r_kind   <= KIND_USER;
            r_dstart <= '0;
            r_acc    <= '0;
            r_pos    <= '0;
            r_found  <= '0;
        end else if (r_in_valid && w_advance) begin
            r_phase  <= n_phase;
            r_kind   <= n_kind;
            r_dstart <= n_dstart;
            r_acc    <= n_acc;
            r_pos    <= n_pos;
            r_found  <= n_found;
        end
    end

    // ------------------------------------------------------------------
    // Result register
    // ------------------------------------------------------------------
    logic  r_out_valid;
    t_kind r_out_kind;
    t_opos r_out_begin;
    t_opos r_out_end;
    t_id   r_out_id;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_advance) begin
            r_out_valid <= r_in_valid && w_emit;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_advance && r_in_valid && w_emit) begin
            r_out_kind  <= w_ekind;
            r_out_begin <= t_opos'(w_ebegin);
            r_out_end   <= t_opos'(w_eend);
            r_out_id    <= w_eid;
        end
    end

    assign o_mention.valid        = r_out_valid;
    assign o_mention.mention_kind = r_out_kind;
    assign o_mention.begin_pos    = r_out_begin;
    assign o_mention.end_pos      = r_out_end;
    assign o_mention.mention_id   = r_out_id;

endmodule

[tb/sv/testbench.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for mention_token_scanner_core. A table of directed
// texts runs first, then random texts under a series of max_found settings.
// Every accepted character goes through a local scanner model, and each
// result request is compared field by field with the oldest predicted
// mention.
// ----------------------------------------------------------------------------
module testbench;
    import mts_pkg::*;

    localparam int unsigned POS_BITS        = 16;
    localparam int unsigned IDLE_LIMIT      = 3000;
    localparam int unsigned SETTLE_CYCLES   = 8;
    localparam int unsigned ITEMS_PER_PHASE = 135;
    localparam int unsigned N_PHASES        = 10;
    localparam int unsigned N_DIR           = 27;

    // Scan phases of the local model.
    typedef enum logic [1:0] {
        SEEK_AT,
        WANT_TYPE,
        WANT_DIGIT,
        IN_ID
    } t_scan_phase;

    // How a directed row is checked.
    typedef enum logic [1:0] {
        BY_MODEL,
        NONE_TYPED,
        ONE_TYPED
    } t_row_chk;

    typedef struct packed {
        t_kind kind;
        t_opos bpos;
        t_opos epos;
        t_id   id;
    } t_mention;

    typedef struct packed {
        t_char    ch;
        logic     last;
        t_row_chk chk;
        t_mention hit;
    } t_dir_row;

    localparam t_mention NO_HIT = '0;

    // Directed texts: everyone, shortest user id, saturating role id, type
    // without digit, id ended by a new at sign, and a type on the last byte.
    localparam t_dir_row DIR_ROWS [N_DIR] = '{
        '{CH_AT,   1'b0, NONE_TYPED, NO_HIT},
        '{CH_ALL,  1'b1, ONE_TYPED,  '{KIND_ALL, 16'd0, 16'd1, 31'd0}},
        '{CH_AT,   1'b0, NONE_TYPED, NO_HIT},
        '{CH_USER, 1'b0, NONE_TYPED, NO_HIT},
        '{CH_ZERO, 1'b1, ONE_TYPED,  '{KIND_USER, 16'd0, 16'd2, 31'd0}},
        '{CH_AT,   1'b0, NONE_TYPED, NO_HIT},
        '{CH_ROLE, 1'b0, NONE_TYPED, NO_HIT},
        '{CH_NINE, 1'b0, NONE_TYPED, NO_HIT},
        '{CH_NINE, 1'b0, NONE_TYPED, NO_HIT},
        '{CH_NINE, 1'b0, NONE_TYPED, NO_HIT},
        '{CH_NINE, 1'b0, NONE_TYPED, NO_HIT},
        '{CH_NINE, 1'b0, NONE_TYPED, NO_HIT},
        '{CH_NINE, 1'b0, NONE_TYPED, NO_HIT},
        '{CH_NINE, 1'b0, NONE_TYPED, NO_HIT},
        '{CH_NINE, 1'b0, NONE_TYPED, NO_HIT},
        '{CH_NINE, 1'b0, NONE_TYPED, NO_HIT},
        '{CH_NINE, 1'b1, ONE_TYPED,  '{KIND_ROLE, 16'd0, 16'd11, ID_MAX}},
        '{CH_AT,   1'b0, BY_MODEL,   NO_HIT},
        '{CH_USER, 1'b0, BY_MODEL,   NO_HIT},
        '{CH_ALL,  1'b1, BY_MODEL,   NO_HIT},
        '{CH_AT,   1'b0, BY_MODEL,   NO_HIT},
        '{CH_USER, 1'b0, BY_MODEL,   NO_HIT},
        '{t_char'(CH_ZERO + 8'd5), 1'b0, BY_MODEL, NO_HIT},
        '{CH_AT,   1'b0, BY_MODEL,   NO_HIT},
        '{CH_ALL,  1'b1, BY_MODEL,   NO_HIT},
        '{CH_AT,   1'b0, BY_MODEL,   NO_HIT},
        '{CH_ROLE, 1'b1, NONE_TYPED, NO_HIT}
    };

    logic  i_clk   = 1'b0;
    logic  i_rst_n = 1'b0;
    logic  i_cfg_wr_en;
    t_cnt  i_cfg_wr_data;

    mts_text_if    text_ch ();
    mts_mention_if mention_ch ();

    mention_token_scanner_core #(
        .POS_BITS (POS_BITS)
    ) dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_text        (text_ch),
        .o_mention     (mention_ch),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data)
    );

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    // Local copy of the scanner state and its one register.
    t_scan_phase scan_st;
    t_kind       kind_pend;
    t_opos       first_digit_pos;
    t_id         id_sum;
    t_opos       cur_pos;
    t_cnt        hits_in_text;
    t_cnt        limit_reg;

    t_mention    mention_q [$];
    t_char       text_buf [$];
    int unsigned mismatches  = 0;
    int unsigned quiet_cycles = 0;

    function automatic bit is_digit(t_char c);
        return c >= CH_ZERO && c <= CH_NINE;
    endfunction

    // Accumulate one decimal digit, clamp at the largest id.
    function automatic t_id next_id(t_id acc, t_char c);
        logic [35:0] v;
        v = 36'(acc) * 36'd10 + 36'(c - CH_ZERO);
        return (v > 36'(ID_MAX)) ? ID_MAX : t_id'(v);
    endfunction

    // Queue one predicted mention at the tail.
    task automatic expect_mention(t_mention m);
        mention_q = {mention_q, m};
    endtask

    // Append one character to the text being built.
    task automatic add_char(t_char c);
        text_buf = {text_buf, c};
    endtask

    task automatic clear_scan();
        scan_st         = SEEK_AT;
        kind_pend       = KIND_USER;
        first_digit_pos = '0;
        id_sum          = '0;
        cur_pos         = '0;
        hits_in_text    = '0;
    endtask

    task automatic record(t_kind k, t_opos b, t_opos e, t_id id,
                          output bit hit, output t_mention m);
        m.kind = k;
        m.bpos = b;
        m.epos = e;
        m.id   = id;
        hit    = 1'b1;
        if (hits_in_text != CNT_MAX) hits_in_text++;
    endtask

    // Judge a byte that stands where a type character may follow an at sign.
    task automatic judge_type(t_char c, t_opos p, output bit hit, output t_mention m);
        hit = 1'b0;
        m   = NO_HIT;
        if (c == CH_USER || c == CH_ROLE) begin
            kind_pend = (c == CH_USER) ? KIND_USER : KIND_ROLE;
            scan_st   = WANT_DIGIT;
        end else begin
            scan_st = SEEK_AT;
            if (c == CH_ALL) record(KIND_ALL, p - 16'd1, p, '0, hit, m);
        end
    endtask

    // Advance the model by one accepted character; report a mention if one closes.
    task automatic scan_char(t_char c, logic last, output bit hit, output t_mention m);
        t_opos p;
        p   = cur_pos;
        hit = 1'b0;
        m   = NO_HIT;
        if (hits_in_text < limit_reg) begin
            case (scan_st)
                SEEK_AT: begin
                    if (c == CH_AT) scan_st = WANT_TYPE;
                end
                WANT_TYPE: begin
                    judge_type(c, p, hit, m);
                end
                WANT_DIGIT: begin
                    if (is_digit(c)) begin
                        first_digit_pos = p;
                        id_sum          = next_id('0, c);
                        scan_st         = IN_ID;
                        if (last) begin
                            scan_st = SEEK_AT;
                            record(kind_pend, first_digit_pos - 16'd2, p, id_sum, hit, m);
                        end
                    end else begin
                        // A type character not followed by a digit still
                        // leaves the next byte judged as a type character.
                        judge_type(c, p, hit, m);
                    end
                end
                default: begin
                    if (is_digit(c)) begin
                        id_sum = next_id(id_sum, c);
                        if (last) begin
                            scan_st = SEEK_AT;
                            record(kind_pend, first_digit_pos - 16'd2, p, id_sum, hit, m);
                        end
                    end else begin
                        scan_st = SEEK_AT;
                        record(kind_pend, first_digit_pos - 16'd2, p - 16'd1, id_sum,
                               hit, m);
                        // Rescan the terminator for an at sign unless the
                        // limit was just reached.
                        if (hits_in_text < limit_reg && c == CH_AT) scan_st = WANT_TYPE;
                    end
                end
            endcase
        end
        cur_pos = p + 16'd1;
        if (last) clear_scan();
    endtask

    // Offer one character request and hold it until the scanner takes it.
    task automatic send_char(t_char c, logic last);
        int unsigned gap;
        gap = $urandom_range(0, 14);
        if (gap != 0) begin
            text_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        text_ch.valid     <= 1'b1;
        text_ch.text_char <= c;
        text_ch.text_last <= last;
        @(posedge i_clk);
        while (!text_ch.ready) @(posedge i_clk);
    endtask

    task automatic feed(t_char c, logic last);
        bit       hit;
        t_mention m;
        send_char(c, last);
        scan_char(c, last, hit, m);
        if (hit) expect_mention(m);
    endtask

    // Drop the request line, wait for every predicted mention, then let the
    // pipeline empty before anything touches the register.
    task automatic drain();
        text_ch.valid <= 1'b0;
        while (mention_q.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic set_limit(t_cnt v);
        i_cfg_wr_en   <= 1'b1;
        i_cfg_wr_data <= v;
        @(posedge i_clk);
        i_cfg_wr_en   <= 1'b0;
        limit_reg      = v;
    endtask

    task automatic push_id_digits(int unsigned nd);
        repeat (nd) add_char(t_char'(CH_ZERO + $urandom_range(0, 9)));
    endtask

    // Build one random text: well-formed mentions in half of the draws, with noise and
    // broken mentions mixed in. Long texts push past the mention limit.
    task automatic build_text();
        int unsigned nseg;
        int unsigned seg_sel;
        string       edge_id;
        text_buf.delete();
        nseg = ($urandom_range(0, 7) == 0) ? $urandom_range(20, 40) : $urandom_range(1, 6);
        repeat (nseg) begin
            seg_sel = $urandom_range(0, 9);
            case (seg_sel)
                0, 1, 2: begin
                    add_char(CH_AT);
                    add_char($urandom_range(0, 1) ? CH_USER : CH_ROLE);
                    push_id_digits(($urandom_range(0, 5) == 0) ? $urandom_range(9, 12)
                                                             : $urandom_range(1, 5));
                end
                3: begin
                    add_char(CH_AT);
                    add_char(CH_ALL);
                end
                4: begin
                    // Ids right at and just past the saturation point.
                    edge_id = $urandom_range(0, 1) ? "2147483647" : "2147483648";
                    add_char(CH_AT);
                    add_char($urandom_range(0, 1) ? CH_USER : CH_ROLE);
                    for (int i = 0; i < edge_id.len(); i++) add_char(t_char'(edge_id[i]));
                end
                5, 6: begin
                    repeat ($urandom_range(1, 4))
                        add_char(t_char'($urandom_range(0, 255)));
                end
                7: begin
                    add_char(CH_AT);
                    add_char(t_char'($urandom_range(0, 255)));
                end
                8: begin
                    add_char(CH_AT);
                    add_char($urandom_range(0, 1) ? CH_USER : CH_ROLE);
                    add_char(t_char'($urandom_range(0, 255)));
                end
                default: begin
                    add_char(CH_AT);
                    add_char(CH_AT);
                end
            endcase
        end
    endtask

    function automatic void check_field(string what, longint unsigned want,
                                        longint unsigned got);
        if (want != got) begin
            $display("%0d ns: %s expected %0d, got %0d", $time, what, want, got);
            mismatches++;
        end
    endfunction

    // Compare every mention request taken from the scanner with the oldest
    // prediction.
    always @(posedge i_clk) begin : result_check
        t_mention want;
        if (i_rst_n && mention_ch.valid && mention_ch.ready) begin
            if (mention_q.size() == 0) begin
                $display("%0d ns: mention expected none, got kind %0d begin %0d end %0d id %0d",
                         $time, mention_ch.mention_kind, mention_ch.begin_pos,
                         mention_ch.end_pos, mention_ch.mention_id);
                mismatches++;
            end else begin
                want = mention_q.pop_front();
                check_field("mention_kind", want.kind, mention_ch.mention_kind);
                check_field("begin_pos", want.bpos, mention_ch.begin_pos);
                check_field("end_pos", want.epos, mention_ch.end_pos);
                check_field("mention_id", want.id, mention_ch.mention_id);
            end
        end
    end

    // End the run if neither channel moves a request for too long.
    always @(posedge i_clk) begin : watchdog
        if ((text_ch.valid && text_ch.ready) || (mention_ch.valid && mention_ch.ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles == IDLE_LIMIT) begin
            $display("testbench: errors");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // Result side: draw a stall for every mention, then hold ready until one
    // is taken. With no stall, ready stays high across requests.
    initial begin : result_sink
        int unsigned gap;
        mention_ch.ready <= 1'b0;
        do @(posedge i_clk); while (!i_rst_n);
        forever begin
            gap = $urandom_range(0, 14);
            if (gap != 0) begin
                mention_ch.ready <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            mention_ch.ready <= 1'b1;
            @(posedge i_clk);
            while (!mention_ch.valid) @(posedge i_clk);
        end
    end

    initial begin : stimulus
        int unsigned limit_plan [N_PHASES];
        int unsigned sent;
        bit          hit;
        t_mention    m;

        text_ch.valid     <= 1'b0;
        text_ch.text_char <= '0;
        text_ch.text_last <= 1'b0;
        i_cfg_wr_en       <= 1'b0;
        i_cfg_wr_data     <= '0;
        clear_scan();
        limit_reg = MAX_FOUND_RST;

        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed table, run with the reset limit.
        for (int r = 0; r < N_DIR; r++) begin
            send_char(DIR_ROWS[r].ch, DIR_ROWS[r].last);
            scan_char(DIR_ROWS[r].ch, DIR_ROWS[r].last, hit, m);
            case (DIR_ROWS[r].chk)
                BY_MODEL:  if (hit) expect_mention(m);
                ONE_TYPED: expect_mention(DIR_ROWS[r].hit);
                default:   ;
            endcase
        end

        // Random texts under several limits: the extremes, tiny limits that
        // stop the scan early, the reset limit, and a few drawn at random.
        limit_plan = '{CNT_MAX, 0, 1, 3, 2, MAX_FOUND_RST, $urandom_range(0, 255),
                       $urandom_range(4, 20), $urandom_range(0, 8), $urandom_range(0, 255)};
        for (int ph = 0; ph < N_PHASES; ph++) begin
            drain();
            set_limit(t_cnt'(limit_plan[ph]));
            sent = 0;
            while (sent < ITEMS_PER_PHASE) begin
                build_text();
                foreach (text_buf[i]) feed(text_buf[i], i == text_buf.size() - 1);
                sent += text_buf.size();
            end
        end

        drain();
        if (mismatches == 0) begin
            $display("testbench: clean");
        end else begin
            $display("testbench: errors");
        end
        $finish;
    end

endmodule

[files.f]
rtl/mts_pkg.sv
rtl/mts_text_if.sv
rtl/mts_mention_if.sv
rtl/mention_token_scanner_core.sv
tb/sv/testbench.sv
